// ----- design/chmm_pkg.sv -----
package chmm_pkg;

  // Cache geometry
  localparam int SLOT_BITS = 10;
  localparam int SLOTS     = 1 << SLOT_BITS;
  localparam int WAY_BITS  = 2;
  localparam int WAYS      = 1 << WAY_BITS;
  localparam int ROW_BITS  = SLOT_BITS - WAY_BITS;
  localparam int ROWS      = 1 << ROW_BITS;

  // Field widths
  localparam int ADDR_BITS = 32;
  localparam int TAG_W     = ADDR_BITS;
  localparam int CNT_W     = 32;
  localparam int TIME_W    = 40;
  localparam int OFF_W     = 5;
  localparam int SLOG_W    = 4;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;

  // Cost model
  localparam int MISS_COST = 100;
  localparam int WAY4_COST = 3;
  localparam int SLOG_MIN  = 2;

  // Register reset values
  localparam logic [OFF_W-1:0]  OFF_RST  = OFF_W'(4);
  localparam logic [SLOG_W-1:0] SLOG_RST = SLOG_W'(10);

  // Organization codes
  localparam logic [MODE_W-1:0] MODE_DIRECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PSEUDO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FOUR   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd2;

  typedef logic [TAG_W-1:0] tag_t;

  // One memory row holds a group of four slots with their valid bits
  typedef struct packed {
    logic [WAYS-1:0] valid;
    tag_t [WAYS-1:0] tag;
  } row_t;

  localparam int ROW_W = WAYS * (TAG_W + 1);

  // Outcome of one lookup
  typedef struct packed {
    logic hit;
    logic probe;
    row_t row;
  } upd_t;

endpackage

// ----- design/chmm_in_if.sv -----
interface chmm_in_if;
  logic                          valid;
  logic                          ready;
  logic [chmm_pkg::ADDR_BITS-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

// ----- design/chmm_out_if.sv -----
interface chmm_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [chmm_pkg::CNT_W-1:0]  miss_count;
  logic [chmm_pkg::CNT_W-1:0]  access_count;
  logic [chmm_pkg::TIME_W-1:0] total_time;

  modport source (output valid, output hit, output miss_count, output access_count,
                  output total_time, input ready);
  modport sink (input valid, input hit, input miss_count, input access_count,
                input total_time, output ready);
endinterface

// ----- design/chmm_ram.sv -----
module chmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/chmm_row_upd.sv -----
module chmm_row_upd (
  input  chmm_pkg::row_t               row_i,
  input  chmm_pkg::tag_t               blk_i,
  input  logic [chmm_pkg::WAY_BITS-1:0] way_i,
  input  logic [chmm_pkg::MODE_W-1:0]   mode_i,
  output chmm_pkg::upd_t               upd_o
);

  logic [chmm_pkg::WAY_BITS-1:0] first_w;
  logic [chmm_pkg::WAY_BITS-1:0] second_w;
  logic [chmm_pkg::WAY_BITS-1:0] stop;
  logic                          found;

  assign first_w  = {way_i[chmm_pkg::WAY_BITS-1:1], 1'b0};
  assign second_w = {way_i[chmm_pkg::WAY_BITS-1:1], 1'b1};

  // Check the set and build the row to write back
  always_comb begin
    upd_o.hit   = 1'b0;
    upd_o.probe = 1'b0;
    upd_o.row   = row_i;
    stop        = chmm_pkg::WAY_BITS'(chmm_pkg::WAYS - 1);
    found       = 1'b0;
    unique case (mode_i)
      chmm_pkg::MODE_PSEUDO: begin
        if (row_i.valid[first_w] && row_i.tag[first_w] == blk_i) begin
          upd_o.hit = 1'b1;
        end else if (!row_i.valid[first_w]) begin
          upd_o.probe            = 1'b1;
          upd_o.row.tag[first_w]   = blk_i;
          upd_o.row.valid[first_w] = 1'b1;
        end else begin
          upd_o.probe             = 1'b1;
          upd_o.hit               = row_i.valid[second_w] && row_i.tag[second_w] == blk_i;
          upd_o.row.tag[second_w]   = row_i.tag[first_w];
          upd_o.row.tag[first_w]    = blk_i;
          upd_o.row.valid[second_w] = 1'b1;
        end
      end
      chmm_pkg::MODE_FOUR: begin
        // Scan for the first empty or matching way
        for (int k = 0; k < chmm_pkg::WAYS; k++) begin
          if (!found) begin
            if (!row_i.valid[k]) begin
              stop  = chmm_pkg::WAY_BITS'(k);
              found = 1'b1;
            end else if (row_i.tag[k] == blk_i) begin
              upd_o.hit = 1'b1;
              stop      = chmm_pkg::WAY_BITS'(k);
              found     = 1'b1;
            end
          end
        end
        // Shift the ways in front of the stop back and put the block in front
        for (int k = 1; k < chmm_pkg::WAYS; k++) begin
          if (chmm_pkg::WAY_BITS'(k) <= stop) begin
            upd_o.row.tag[k] = row_i.tag[k-1];
          end
        end
        upd_o.row.tag[0]     = blk_i;
        upd_o.row.valid[stop] = 1'b1;
      end
      default: begin
        upd_o.hit = row_i.valid[way_i] && row_i.tag[way_i] == blk_i;
        if (!upd_o.hit) begin
          upd_o.row.tag[way_i]   = blk_i;
          upd_o.row.valid[way_i] = 1'b1;
        end
      end
    endcase
  end

endmodule

// ----- design/chmm_stats.sv -----
module chmm_stats (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd_en,
  input  logic                          hit,
  input  logic                          probe,
  input  logic [chmm_pkg::MODE_W-1:0]    mode,
  output logic [chmm_pkg::CNT_W-1:0]     misses,
  output logic [chmm_pkg::CNT_W-1:0]     accesses,
  output logic [chmm_pkg::TIME_W-1:0]    total_time
);

  localparam int SUM_W = chmm_pkg::TIME_W + 2;
  localparam logic [chmm_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic [chmm_pkg::CNT_W-1:0] misses_r, misses_nxt;
  logic [chmm_pkg::CNT_W-1:0] accesses_r, accesses_nxt;
  logic [chmm_pkg::CNT_W-1:0] probes_r, probes_nxt;
  logic [SUM_W-1:0]           miss_cost;
  logic [SUM_W-1:0]           acc_cost;
  logic [SUM_W-1:0]           probe_cost;
  logic [SUM_W-1:0]           sum;

  // Saturating counter advance
  always_comb begin
    misses_nxt   = misses_r;
    accesses_nxt = accesses_r;
    probes_nxt   = probes_r;
    if (upd_en) begin
      if (accesses_r != CNT_MAX) begin
        accesses_nxt = accesses_r + 1'b1;
      end
      if (!hit && misses_r != CNT_MAX) begin
        misses_nxt = misses_r + 1'b1;
      end
      if (probe && probes_r != CNT_MAX) begin
        probes_nxt = probes_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      misses_r   <= '0;
      accesses_r <= '0;
      probes_r   <= '0;
    end else begin
      misses_r   <= misses_nxt;
      accesses_r <= accesses_nxt;
      probes_r   <= probes_nxt;
    end
  end

  // Cost formula from the settled counters
  always_comb begin
    miss_cost  = SUM_W'(misses_r) * SUM_W'(chmm_pkg::MISS_COST);
    acc_cost   = (mode == chmm_pkg::MODE_FOUR) ?
                 SUM_W'(accesses_r) * SUM_W'(chmm_pkg::WAY4_COST) : SUM_W'(accesses_r);
    probe_cost = (mode == chmm_pkg::MODE_PSEUDO) ? SUM_W'(probes_r) : '0;
    sum        = miss_cost + acc_cost + probe_cost;
    if (sum[SUM_W-1:chmm_pkg::TIME_W] != '0) begin
      total_time = '1;
    end else begin
      total_time = sum[chmm_pkg::TIME_W-1:0];
    end
  end

  assign misses   = misses_r;
  assign accesses = accesses_r;

endmodule

// ----- design/cache_hit_miss_model_unit.sv -----
// A taken address is looked up in the lookup state, then its result waits in the done
// state until the output register is free. Each access reads a four-slot row of the
// tag memory and writes it back, and the next read is issued as the result is loaded.
// Reset: counters and state clear, configuration takes reset values, and the tag memory
// is swept one row a cycle while in_chan.ready is low; config writes are always taken.
module cache_hit_miss_model_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  chmm_in_if.sink                          in_chan,
  chmm_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [chmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chmm_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam int SLOT_W = chmm_pkg::SLOT_BITS;

  logic [1:0]                       state_r, state_nxt;
  logic [chmm_pkg::ROW_BITS-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [chmm_pkg::OFF_W-1:0]        line_offset_bits_r;
  logic [chmm_pkg::SLOG_W-1:0]       slot_count_log2_r;
  logic [chmm_pkg::MODE_W-1:0]       mode_cfg_r;

  logic                             in_acc;
  logic                             out_free;
  logic                             out_load;
  chmm_pkg::tag_t                   blk;
  logic [chmm_pkg::SLOG_W-1:0]       slog;
  logic [SLOT_W:0]                  slot_span;
  logic [SLOT_W-1:0]                slot_mask;
  logic [SLOT_W-1:0]                slot;
  logic [chmm_pkg::MODE_W-1:0]       mode_eff;

  chmm_pkg::tag_t                   blk_r;
  logic [chmm_pkg::WAY_BITS-1:0]     way_r;
  logic [chmm_pkg::MODE_W-1:0]       mode_r;
  logic                             hit_r;

  logic                             ram_we;
  logic [chmm_pkg::ROW_BITS-1:0]     ram_waddr;
  logic [chmm_pkg::ROW_BITS-1:0]     ram_raddr_r;
  logic [chmm_pkg::ROW_W-1:0]        ram_wdata;
  logic [chmm_pkg::ROW_W-1:0]        ram_rdata;
  chmm_pkg::row_t                   rd_row;
  chmm_pkg::upd_t                   upd;

  logic [chmm_pkg::CNT_W-1:0]        misses;
  logic [chmm_pkg::CNT_W-1:0]        accesses;
  logic [chmm_pkg::TIME_W-1:0]       total_time;

  logic                             out_valid_r;
  logic                             out_hit_r;
  logic [chmm_pkg::CNT_W-1:0]        out_miss_r;
  logic [chmm_pkg::CNT_W-1:0]        out_acc_r;
  logic [chmm_pkg::TIME_W-1:0]       out_time_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_offset_bits_r <= chmm_pkg::OFF_RST;
      slot_count_log2_r  <= chmm_pkg::SLOG_RST;
      mode_cfg_r         <= chmm_pkg::MODE_DIRECT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chmm_pkg::CFG_LINE_OFFSET: line_offset_bits_r <= cfg_wdata[chmm_pkg::OFF_W-1:0];
        chmm_pkg::CFG_SLOT_COUNT:  slot_count_log2_r  <= cfg_wdata[chmm_pkg::SLOG_W-1:0];
        chmm_pkg::CFG_MODE:        mode_cfg_r         <= cfg_wdata[chmm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign out_free      = !out_valid_r || out_chan.ready;
  assign out_load      = (state_r == ST_DONE) && out_free;
  assign in_chan.ready = (state_r == ST_IDLE) || out_load;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Block address and slot of the incoming beat
  always_comb begin
    blk = chmm_pkg::tag_t'(in_chan.address >> line_offset_bits_r);
    if (slot_count_log2_r < chmm_pkg::SLOG_W'(chmm_pkg::SLOG_MIN)) begin
      slog = chmm_pkg::SLOG_W'(chmm_pkg::SLOG_MIN);
    end else if (slot_count_log2_r > chmm_pkg::SLOG_W'(SLOT_W)) begin
      slog = chmm_pkg::SLOG_W'(SLOT_W);
    end else begin
      slog = slot_count_log2_r;
    end
    slot_span = (SLOT_W + 1)'(1) << slog;
    slot_mask = SLOT_W'(slot_span - 1'b1);
    mode_eff  = (mode_cfg_r == chmm_pkg::MODE_UNUSED) ? chmm_pkg::MODE_DIRECT : mode_cfg_r;
    // Set number from the low block bits, scaled by the set size
    unique case (mode_eff)
      chmm_pkg::MODE_PSEUDO: slot = (blk[SLOT_W-1:0] & (slot_mask >> 1)) << 1;
      chmm_pkg::MODE_FOUR:   slot = (blk[SLOT_W-1:0] & (slot_mask >> 2)) << 2;
      default:               slot = blk[SLOT_W-1:0] & slot_mask;
    endcase
  end

  // Hold the beat for the lookup
  always_ff @(posedge clk) begin
    if (in_acc) begin
      blk_r  <= blk;
      way_r  <= slot[chmm_pkg::WAY_BITS-1:0];
      mode_r <= mode_eff;
    end
    if (state_r == ST_LOOK) begin
      hit_r <= upd.hit;
    end
  end

  // Tag memory: clearing sweep or write back of the updated row
  always_comb begin
    ram_we    = (state_r == ST_CLEAR) || (state_r == ST_LOOK);
    ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : ram_raddr_r;
    ram_wdata = (state_r == ST_CLEAR) ? '0 : chmm_pkg::ROW_W'(upd.row);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ram_raddr_r <= slot[SLOT_W-1:chmm_pkg::WAY_BITS];
    end
  end

  chmm_ram #(
    .WIDTH (chmm_pkg::ROW_W),
    .DEPTH (chmm_pkg::ROWS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (slot[SLOT_W-1:chmm_pkg::WAY_BITS]),
    .rdata (ram_rdata)
  );

  assign rd_row = chmm_pkg::row_t'(ram_rdata);

  chmm_row_upd u_row_upd (
    .row_i  (rd_row),
    .blk_i  (blk_r),
    .way_i  (way_r),
    .mode_i (mode_r),
    .upd_o  (upd)
  );

  chmm_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd_en     (state_r == ST_LOOK),
    .hit        (upd.hit),
    .probe      (upd.probe),
    .mode       (mode_r),
    .misses     (misses),
    .accesses   (accesses),
    .total_time (total_time)
  );

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = in_acc ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r  <= hit_r;
      out_miss_r <= misses;
      out_acc_r  <= accesses;
      out_time_r <= total_time;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.hit          = out_hit_r;
  assign out_chan.miss_count   = out_miss_r;
  assign out_chan.access_count = out_acc_r;
  assign out_chan.total_time   = out_time_r;

endmodule

// ----- bench/cache_model_tb_pkg.sv -----
`timescale 1ns / 1ps

package cache_model_tb_pkg;
  import chmm_pkg::*;

  // One lookup outcome as the result channel shows it
  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  access_count;
    logic [TIME_W-1:0] total_time;
  } lookup_t;

  localparam logic [TIME_W-1:0] TIME_SAT   = '1;
  localparam int                MAX_REPORT = 10;

  class cache_scoreboard;
    tag_t              tags [SLOTS];
    bit                present [SLOTS];
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  accesses;
    logic [CNT_W-1:0]  probes;
    logic [OFF_W-1:0]  line_off;
    logic [SLOG_W-1:0] slot_log2;
    logic [MODE_W-1:0] org_sel;
    lookup_t           expected_lookups [$];
    int                errors;
    int                checked;
    int                hit_count;
    int                per_mode [4];

    function new();
      foreach (present[i]) present[i] = 1'b0;
      foreach (tags[i]) tags[i] = '0;
      foreach (per_mode[i]) per_mode[i] = 0;
      misses    = '0;
      accesses  = '0;
      probes    = '0;
      line_off  = OFF_RST;
      slot_log2 = SLOG_RST;
      org_sel   = MODE_DIRECT;
      errors    = 0;
      checked   = 0;
      hit_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_LINE_OFFSET: line_off = data[OFF_W-1:0];
        CFG_SLOT_COUNT:  slot_log2 = data[SLOG_W-1:0];
        CFG_MODE:        org_sel = data[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    // Look one address up in the shadow tag store and update it
    function lookup_t predict_lookup(tag_t addr);
      tag_t              blk;
      int                slog;
      int                n;
      int                base;
      int                stop;
      int                w;
      logic [MODE_W-1:0] org;
      logic              hit;
      logic              found;
      logic [63:0]       cost;
      lookup_t           r;
      blk = addr >> line_off;
      slog = slot_log2;
      if (slog < SLOG_MIN) slog = SLOG_MIN;
      if (slog > SLOT_BITS) slog = SLOT_BITS;
      n = 1 << slog;
      org = (org_sel == MODE_UNUSED) ? MODE_DIRECT : org_sel;
      hit = 1'b0;
      found = 1'b0;
      per_mode[org_sel]++;
      accesses = sat_inc(accesses);
      case (org)
        MODE_DIRECT: begin
          base = blk & (n - 1);
          hit = present[base] && tags[base] == blk;
          if (!hit) begin
            tags[base] = blk;
            present[base] = 1'b1;
          end
        end
        MODE_PSEUDO: begin
          base = (blk & (n / 2 - 1)) << 1;
          if (present[base] && tags[base] == blk) begin
            hit = 1'b1;
          end else begin
            probes = sat_inc(probes);
            // Second slot counts only behind a valid first slot; old first tag moves down
            if (present[base]) begin
              hit = present[base + 1] && tags[base + 1] == blk;
              tags[base + 1] = tags[base];
              present[base + 1] = 1'b1;
            end
            tags[base] = blk;
            present[base] = 1'b1;
          end
        end
        default: begin
          // Scan to the first empty or matching way, then move the block to the front
          base = (blk & (n / 4 - 1)) << 2;
          stop = WAYS - 1;
          for (w = 0; w < WAYS && !found; w++) begin
            if (!present[base + w]) begin
              stop = w;
              found = 1'b1;
            end else if (tags[base + w] == blk) begin
              stop = w;
              hit = 1'b1;
              found = 1'b1;
            end
          end
          for (w = stop; w > 0; w--) tags[base + w] = tags[base + w - 1];
          tags[base] = blk;
          present[base + stop] = 1'b1;
        end
      endcase
      if (!hit) misses = sat_inc(misses);
      if (hit) hit_count++;

      // Access time by organization
      cost = 64'(misses) * MISS_COST;
      if (org == MODE_FOUR) cost += 64'(accesses) * WAY4_COST;
      else cost += 64'(accesses);
      if (org == MODE_PSEUDO) cost += 64'(probes);
      if (cost > 64'(TIME_SAT)) cost = 64'(TIME_SAT);

      r.hit          = hit;
      r.miss_count   = misses;
      r.access_count = accesses;
      r.total_time   = cost[TIME_W-1:0];
      return r;
    endfunction

    function void note_access(tag_t addr);
      expected_lookups.push_back(predict_lookup(addr));
    endfunction

    function void check_lookup(lookup_t got);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("ERROR: result beat with no lookup pending: hit=%0b miss=%0d acc=%0d tot=%0d",
                   got.hit, got.miss_count, got.access_count, got.total_time);
        return;
      end
      want = expected_lookups.pop_front();
      checked++;
      if (got.hit !== want.hit || got.miss_count !== want.miss_count ||
          got.access_count !== want.access_count || got.total_time !== want.total_time) begin
        errors++;
        if (errors <= MAX_REPORT)
          $display("ERROR: lookup %0d: expected hit=%0b miss=%0d acc=%0d tot=%0d, got hit=%0b miss=%0d acc=%0d tot=%0d",
                   checked, want.hit, want.miss_count, want.access_count, want.total_time,
                   got.hit, got.miss_count, got.access_count, got.total_time);
      end
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_cache_hit_miss_model_unit.sv -----
`timescale 1ns / 1ps

module tb_cache_hit_miss_model_unit;
  import chmm_pkg::*;
  import cache_model_tb_pkg::*;

  localparam int                   STALL_LIMIT = 2000;
  localparam int                   POOL_SIZE   = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  chmm_in_if  in_chan ();
  chmm_out_if out_chan ();

  cache_hit_miss_model_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cache_scoreboard sb;
  int              idle_cycles = 0;
  int              settings = 0;
  bit              calm = 1'b0;
  logic [31:0]     hot_pool [POOL_SIZE];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: stall at random unless in a calm stretch
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= calm || ($urandom_range(0, 99) >= 34);
    end
  end

  // Sample both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (in_chan.valid && in_chan.ready) sb.note_access(in_chan.address);
      if (out_chan.valid && out_chan.ready)
        sb.check_lookup('{hit: out_chan.hit, miss_count: out_chan.miss_count,
                          access_count: out_chan.access_count,
                          total_time: out_chan.total_time});
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("ERROR: no beat for %0d cycles, %0d lookups outstanding", STALL_LIMIT,
             sb.pending());
    $display("tb_cache_hit_miss_model_unit NOT OK");
    $finish;
  end

  // Offer one address and hold it until taken
  task automatic send_addr(input logic [31:0] a);
    if (!calm)
      while ($urandom_range(0, 99) < 34) begin
        in_chan.valid <= 1'b0;
        @(negedge clk);
      end
    in_chan.valid   <= 1'b1;
    in_chan.address <= a;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every lookup has come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Upper data bits beyond the slot-count and mode registers are random and must be ignored
  task automatic configure(input logic [OFF_W-1:0] off, input logic [SLOG_W-1:0] slog,
                           input logic [MODE_W-1:0] org);
    drain();
    write_reg(CFG_LINE_OFFSET, off);
    write_reg(CFG_SLOT_COUNT, {1'($urandom), slog});
    write_reg(CFG_MODE, {3'($urandom), org});
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Mostly reuse of hot blocks and same-set conflicts, some fully random noise
  function automatic logic [31:0] pick_addr();
    int          pick;
    int          sh;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    sh = int'(sb.line_off) + int'(sb.slot_log2);
    a = hot_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 55) a = a ^ ($urandom & ((32'h1 << sb.line_off) - 1));
    else if (pick < 85) a = a ^ (32'($urandom_range(1, 7)) << sh);
    else a = $urandom;
    return a;
  endfunction

  task automatic run_phase(input logic [OFF_W-1:0] off, input logic [SLOG_W-1:0] slog,
                           input logic [MODE_W-1:0] org, input int count, input bit pause);
    configure(off, slog, org);
    foreach (hot_pool[i]) hot_pool[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      if (pause && i == count / 2) drain();
      send_addr(pick_addr());
    end
  endtask

  initial begin
    logic [31:0] dir_direct [5];
    logic [31:0] dir_pseudo [6];
    logic [31:0] dir_four [7];
    logic [31:0] dir_wide [4];
    dir_direct = '{32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0000_0000};
    dir_pseudo = '{32'h0, 32'h2, 32'h0, 32'h2, 32'h4, 32'h1};
    dir_four   = '{32'h10, 32'h11, 32'h12, 32'h13, 32'h14, 32'h12, 32'h10};
    dir_wide   = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};

    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.address = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    sb = new();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, direct-mapped hit, conflict eviction, extreme addresses
    foreach (dir_direct[i]) send_addr(dir_direct[i]);
    drain();
    write_reg(CFG_SPARE, 5'($urandom));
    // Pseudo-associative on two sets: empty first slot, second-slot hits with swap
    configure(5'd0, 4'd2, MODE_PSEUDO);
    foreach (dir_pseudo[i]) send_addr(dir_pseudo[i]);
    // Four-way on one set: fill, drop of the last way, hit in the middle
    configure(5'd0, 4'd2, MODE_FOUR);
    foreach (dir_four[i]) send_addr(dir_four[i]);
    // Widest line offset under the unused organization code
    configure(5'd31, 4'd15, MODE_UNUSED);
    foreach (dir_wide[i]) send_addr(dir_wide[i]);

    // Random phases over a spread of settings
    run_phase(5'd4, 4'd10, MODE_DIRECT, 150, 1'b1);
    run_phase(5'd0, 4'd2, MODE_PSEUDO, 120, 1'b0);
    calm = 1'b1;
    run_phase(5'd16, 4'd6, MODE_FOUR, 150, 1'b0);
    calm = 1'b0;
    run_phase(5'd31, 4'd3, MODE_DIRECT, 40, 1'b0);
    run_phase(5'd2, 4'd0, MODE_FOUR, 120, 1'b0);
    run_phase(5'd8, 4'd15, MODE_PSEUDO, 150, 1'b1);
    run_phase(5'd3, 4'd11, MODE_UNUSED, 120, 1'b0);
    run_phase(5'd0, 4'd10, MODE_FOUR, 150, 1'b0);
    run_phase(5'd5, 4'd4, MODE_PSEUDO, 150, 1'b0);
    run_phase(5'd1, 4'd2, MODE_FOUR, 120, 1'b0);
    run_phase(5'd12, 4'd7, MODE_PSEUDO, 110, 1'b0);
    run_phase(5'd6, 4'd1, MODE_DIRECT, 100, 1'b0);

    drain();
    repeat (8) @(negedge clk);

    $display("Checked %0d lookups (%0d hits) across %0d register settings.",
             sb.checked, sb.hit_count, settings);
    $display("Lookups per organization direct/pseudo/four-way/unused: %0d/%0d/%0d/%0d",
             sb.per_mode[0], sb.per_mode[1], sb.per_mode[2], sb.per_mode[3]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_cache_hit_miss_model_unit OK");
    end else begin
      $display("%0d mismatches, %0d lookups outstanding", sb.errors, sb.pending());
      $display("tb_cache_hit_miss_model_unit NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/chmm_pkg.sv
design/chmm_in_if.sv
design/chmm_out_if.sv
design/chmm_ram.sv
design/chmm_row_upd.sv
design/chmm_stats.sv
design/cache_hit_miss_model_unit.sv
bench/cache_model_tb_pkg.sv
bench/tb_cache_hit_miss_model_unit.sv
